// ===== src/trpfl_pkg.sv =====
// Shared types, codes and constants of the two-region page free list.
package trpfl_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_PAGES_DEF  = 4096;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed field widths.
    localparam int ADDR_W  = 56;
    localparam int CNT_W   = 13;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    // Register reset values.
    localparam logic [ADDR_W-1:0] MEM_LO_RST      = 56'd2147483648;
    localparam logic [ADDR_W-1:0] MEM_HI_RST      = 56'd2164260864;
    localparam logic [CNT_W-1:0]  KERN_NPAGES_RST = 13'd1024;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LO      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_HI      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_NPAGES = 2'd2;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_BUILD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ALIGN   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_DER0,
        ST_DER1,
        ST_DER2,
        ST_DER3,
        ST_DER4,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE1,
        ST_FREE2,
        ST_BUILD,
        ST_WALK,
        ST_NOP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic der0;
        logic der1;
        logic der2;
        logic der3;
        logic der4;
        logic do_alloc;
        logic free_chk;
        logic do_free;
        logic build_init;
        logic walk_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
    } ctrl_stat_t;

endpackage

// ===== src/trpfl_ctrl.sv =====
// Controller state machine of the two-region page free list.
module trpfl_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [trpfl_pkg::MODE_W-1:0]  in_mode,
    input  logic                          cfg_we,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output trpfl_pkg::ctrl_cmd_t          cmd,
    input  trpfl_pkg::ctrl_stat_t         stat
);

    trpfl_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= trpfl_pkg::ST_DER0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            trpfl_pkg::ST_DER0: begin
                cmd.der0   = 1'b1;
                state_next = trpfl_pkg::ST_DER1;
            end
            trpfl_pkg::ST_DER1: begin
                cmd.der1   = 1'b1;
                state_next = trpfl_pkg::ST_DER2;
            end
            trpfl_pkg::ST_DER2: begin
                cmd.der2   = 1'b1;
                state_next = trpfl_pkg::ST_DER3;
            end
            trpfl_pkg::ST_DER3: begin
                cmd.der3   = 1'b1;
                state_next = trpfl_pkg::ST_DER4;
            end
            trpfl_pkg::ST_DER4: begin
                cmd.der4   = 1'b1;
                state_next = trpfl_pkg::ST_IDLE;
            end
            trpfl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (in_mode)
                        trpfl_pkg::MODE_BUILD: state_next = trpfl_pkg::ST_BUILD;
                        trpfl_pkg::MODE_ALLOC: begin
                            cmd.rd_en  = 1'b1;
                            state_next = trpfl_pkg::ST_ALLOC;
                        end
                        trpfl_pkg::MODE_FREE:  state_next = trpfl_pkg::ST_FREE1;
                        default:               state_next = trpfl_pkg::ST_NOP;
                    endcase
                end
            end
            trpfl_pkg::ST_ALLOC: begin
                if (out_free) begin
                    cmd.do_alloc = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = trpfl_pkg::ST_IDLE;
                end
            end
            trpfl_pkg::ST_FREE1: begin
                cmd.free_chk = 1'b1;
                state_next   = trpfl_pkg::ST_FREE2;
            end
            trpfl_pkg::ST_FREE2: begin
                if (out_free) begin
                    cmd.do_free  = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = trpfl_pkg::ST_IDLE;
                end
            end
            trpfl_pkg::ST_BUILD: begin
                cmd.build_init = 1'b1;
                state_next     = trpfl_pkg::ST_WALK;
            end
            trpfl_pkg::ST_WALK: begin
                if (!stat.walk_done) begin
                    cmd.walk_step = 1'b1;
                end else if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = trpfl_pkg::ST_IDLE;
                end
            end
            trpfl_pkg::ST_NOP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = trpfl_pkg::ST_IDLE;
                end
            end
            default: state_next = trpfl_pkg::ST_DER0;
        endcase
        // A register write restarts the pass over the derived bounds.
        if (cfg_we) begin
            state_next = trpfl_pkg::ST_DER0;
        end
    end

    // Output valid: set on a new result, cleared when the beat is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

endmodule

// ===== src/trpfl_dp.sv =====
// Datapath of the two-region page free list: registers, bounds, lists and link memory.
module trpfl_dp #(
    parameter int MAX_PAGES  = trpfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = trpfl_pkg::PAGE_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  trpfl_pkg::ctrl_cmd_t             cmd,
    output trpfl_pkg::ctrl_stat_t            stat,
    input  logic                             cfg_we,
    input  logic [trpfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trpfl_pkg::ADDR_W-1:0]     cfg_data,
    input  logic                             in_side,
    input  logic [trpfl_pkg::ADDR_W-1:0]     in_page,
    output logic [trpfl_pkg::ADDR_W-1:0]     out_got,
    output logic [trpfl_pkg::STAT_W-1:0]     out_status,
    output logic [trpfl_pkg::CNT_W-1:0]      out_free_pages
);

    localparam int A      = trpfl_pkg::ADDR_W;
    localparam int CW     = trpfl_pkg::CNT_W;
    localparam int W1     = A + 1;
    localparam int W2     = A + 2;
    localparam int IDX_W  = $clog2(MAX_PAGES + 1);
    localparam int MA_W   = $clog2(MAX_PAGES);
    localparam int SH     = $clog2(PAGE_BYTES);
    localparam int QW     = W2 - 1 - SH;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_PAGES);

    // Page index of a non-negative byte offset, capped at the null index.
    function automatic logic [IDX_W-1:0] idx_cap(input logic [W2-1:0] d);
        logic [QW-1:0] q;
        q = d[W2-2:SH];
        if (d[W2-1]) begin
            idx_cap = '0;
        end else if (q >= QW'(MAX_PAGES)) begin
            idx_cap = NULL_IDX;
        end else begin
            idx_cap = q[IDX_W-1:0];
        end
    endfunction

    // Count of a page number, saturated to the count width.
    function automatic logic [CW-1:0] cnt_sat(input logic [IDX_W-1:0] n);
        logic [31:0] n32;
        n32 = 32'(n);
        if (n32 >= 32'(trpfl_pkg::CNT_MAX)) begin
            cnt_sat = trpfl_pkg::CNT_MAX;
        end else begin
            cnt_sat = n32[CW-1:0];
        end
    endfunction

    // Configuration registers.
    logic [A-1:0]  mem_lo_reg, mem_hi_reg;
    logic [CW-1:0] kern_npages_reg;

    // Derived bounds.
    logic [W1-1:0]    base_reg, kraw_reg, kup_reg;
    logic [A-1:0]     kend_reg;
    logic [W2-1:0]    dk_reg, de_reg, du_reg;
    logic [IDX_W-1:0] hi_k_reg, hi_u_reg, lo_u_reg;

    // Item registers.
    logic          side_reg;
    logic [A-1:0]  page_reg;
    logic          align_err_reg, region_err_reg;
    logic [W2-1:0] dp_reg;

    // List state.
    logic [IDX_W-1:0] khead_reg, khead_next, uhead_reg, uhead_next;
    logic [CW-1:0]    kcnt_reg, kcnt_next, ucnt_reg, ucnt_next;
    logic [IDX_W-1:0] walk_reg;
    logic [IDX_W-1:0] rd_data_reg;

    // Result registers.
    logic [A-1:0]  got_reg;
    logic [trpfl_pkg::STAT_W-1:0] status_reg;
    logic [CW-1:0] free_pages_reg;

    // Link memory.
    logic [IDX_W-1:0] link_mem [MAX_PAGES];
    logic             mem_we, mem_re;
    logic [MA_W-1:0]  mem_waddr, mem_raddr;
    logic [IDX_W-1:0] mem_wdata;

    // Combinational helpers.
    logic [W1-1:0]    base_sum, kup_sum, got_sum;
    logic [IDX_W-1:0] sel_head, rd_head, nxt_idx, idx_f;
    logic [CW-1:0]    sel_cnt;
    logic             empty, push_ok, user_nonempty;
    logic [A-1:0]     rb, re;
    logic [trpfl_pkg::STAT_W-1:0] status_c;
    logic [A-1:0]     got_c;

    assign stat.walk_done = (walk_reg == hi_u_reg);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_lo_reg      <= trpfl_pkg::MEM_LO_RST;
            mem_hi_reg      <= trpfl_pkg::MEM_HI_RST;
            kern_npages_reg <= trpfl_pkg::KERN_NPAGES_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                trpfl_pkg::CFG_MEM_LO:      mem_lo_reg      <= cfg_data;
                trpfl_pkg::CFG_MEM_HI:      mem_hi_reg      <= cfg_data;
                trpfl_pkg::CFG_KERN_NPAGES: kern_npages_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Derived bounds, one arithmetic step per pass cycle.
    assign base_sum = {1'b0, mem_lo_reg} + W1'(PAGE_BYTES - 1);
    assign kup_sum  = {1'b0, kend_reg} + W1'(PAGE_BYTES - 1);

    always_ff @(posedge aclk) begin
        if (cmd.der0) begin
            base_reg <= {base_sum[W1-1:SH], SH'(0)};
            kraw_reg <= {1'b0, mem_lo_reg} + (W1'(kern_npages_reg) << SH);
        end
        if (cmd.der1) begin
            kend_reg <= (kraw_reg > {1'b0, mem_hi_reg}) ? mem_hi_reg : kraw_reg[A-1:0];
        end
        if (cmd.der2) begin
            kup_reg <= {kup_sum[W1-1:SH], SH'(0)};
            dk_reg  <= {2'b00, kend_reg} - {1'b0, base_reg};
            de_reg  <= {2'b00, mem_hi_reg} - {1'b0, base_reg};
        end
        if (cmd.der3) begin
            hi_k_reg <= idx_cap(dk_reg);
            hi_u_reg <= idx_cap(de_reg);
            du_reg   <= {1'b0, kup_reg} - {1'b0, base_reg};
        end
        if (cmd.der4) begin
            lo_u_reg <= idx_cap(du_reg);
        end
    end

    // Item capture and the free checks.
    assign rb = side_reg ? mem_lo_reg : kend_reg;
    assign re = side_reg ? kend_reg : mem_hi_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            side_reg <= in_side;
            page_reg <= in_page;
        end
        if (cmd.free_chk) begin
            align_err_reg  <= |page_reg[SH-1:0];
            region_err_reg <= (page_reg < rb) || (page_reg >= re);
            dp_reg         <= {2'b00, page_reg} - {1'b0, base_reg};
        end
    end

    // List head, count and result logic.
    assign sel_head      = side_reg ? khead_reg : uhead_reg;
    assign sel_cnt       = side_reg ? kcnt_reg : ucnt_reg;
    assign empty         = (sel_head >= NULL_IDX);
    assign nxt_idx       = (rd_data_reg >= NULL_IDX) ? NULL_IDX : rd_data_reg;
    assign got_sum       = base_reg + (W1'(sel_head) << SH);
    assign idx_f         = idx_cap(dp_reg);
    assign push_ok       = !align_err_reg && !region_err_reg && !dp_reg[W2-1]
                           && (idx_f != NULL_IDX);
    assign user_nonempty = (hi_u_reg > lo_u_reg);

    always_comb begin
        khead_next = khead_reg;
        uhead_next = uhead_reg;
        kcnt_next  = kcnt_reg;
        ucnt_next  = ucnt_reg;
        if (cmd.build_init) begin
            khead_next = (hi_k_reg != '0) ? hi_k_reg - 1'b1 : NULL_IDX;
            kcnt_next  = cnt_sat(hi_k_reg);
            uhead_next = user_nonempty ? hi_u_reg - 1'b1 : NULL_IDX;
            ucnt_next  = user_nonempty ? cnt_sat(hi_u_reg - lo_u_reg) : '0;
        end
        if (cmd.do_alloc && !empty) begin
            if (side_reg) begin
                khead_next = nxt_idx;
                kcnt_next  = (kcnt_reg != '0) ? kcnt_reg - 1'b1 : kcnt_reg;
            end else begin
                uhead_next = nxt_idx;
                ucnt_next  = (ucnt_reg != '0) ? ucnt_reg - 1'b1 : ucnt_reg;
            end
        end
        if (cmd.do_free && push_ok) begin
            if (side_reg) begin
                khead_next = idx_f;
                kcnt_next  = (kcnt_reg != trpfl_pkg::CNT_MAX) ? kcnt_reg + 1'b1 : kcnt_reg;
            end else begin
                uhead_next = idx_f;
                ucnt_next  = (ucnt_reg != trpfl_pkg::CNT_MAX) ? ucnt_reg + 1'b1 : ucnt_reg;
            end
        end
    end

    always_comb begin
        status_c = trpfl_pkg::STAT_OK;
        got_c    = '0;
        if (cmd.do_alloc) begin
            if (empty) begin
                status_c = trpfl_pkg::STAT_EMPTY;
            end else begin
                got_c = got_sum[A-1:0];
            end
        end else if (cmd.do_free) begin
            if (align_err_reg) begin
                status_c = trpfl_pkg::STAT_ALIGN;
            end else if (region_err_reg) begin
                status_c = trpfl_pkg::STAT_OUTSIDE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            khead_reg <= NULL_IDX;
            uhead_reg <= NULL_IDX;
            kcnt_reg  <= '0;
            ucnt_reg  <= '0;
        end else begin
            khead_reg <= khead_next;
            uhead_reg <= uhead_next;
            kcnt_reg  <= kcnt_next;
            ucnt_reg  <= ucnt_next;
        end
    end

    // Build walk counter.
    always_ff @(posedge aclk) begin
        if (cmd.build_init) begin
            walk_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_reg <= walk_reg + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            got_reg        <= got_c;
            status_reg     <= status_c;
            free_pages_reg <= side_reg ? kcnt_next : ucnt_next;
        end
    end

    assign out_got        = got_reg;
    assign out_status     = status_reg;
    assign out_free_pages = free_pages_reg;

    // Link memory ports. The first page of each region ends its list.
    assign rd_head   = in_side ? khead_reg : uhead_reg;
    assign mem_re    = cmd.rd_en && (rd_head < NULL_IDX);
    assign mem_raddr = rd_head[MA_W-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = walk_reg[MA_W-1:0];
        mem_wdata = sel_head;
        if (cmd.walk_step) begin
            mem_we    = 1'b1;
            mem_wdata = ((walk_reg == '0) || (walk_reg == lo_u_reg)) ? NULL_IDX
                                                                      : walk_reg - 1'b1;
        end else if (cmd.do_free && push_ok) begin
            mem_we    = 1'b1;
            mem_waddr = idx_f[MA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

endmodule

// ===== src/two_region_page_free_list_top.sv =====
// Top level of the two-region page free list.
//
// Usage: each input beat on the s_ channel is one operation (build both lists,
// allocate a page, free a page); each gives exactly one result beat on the m_
// channel. The three registers (start of memory, end of memory, kernel page count)
// are written on the cfg_ channel, which is always ready; write them only while
// the block is idle.
// Allocate takes its next link from a registered read of the link memory; free
// registers its address checks before it updates a list; build sets both list
// heads and then walks the N whole pages from the page-rounded start of memory to
// its end, capped at MAX_PAGES, with one link memory write per page; an unused
// mode only loads a result. The result beat is presented in the
// cycle after it is loaded, and the next input beat can be taken in that cycle,
// even while the result is still waiting on m_tready. If the receiver stalls with
// a result pending, the next operation holds in its last state, where an allocate
// or free also makes its list update, until the output register is free.
// After reset, and after every register write, a pass through the states ST_DER0 to
// ST_DER4 recomputes the region bounds with s_tready low. Reset empties both lists.
module two_region_page_free_list_top #(
    parameter int MAX_PAGES  = trpfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = trpfl_pkg::PAGE_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [55:0]                      s_tdata,   // [55:0] page_addr
    input  logic [2:0]                       s_tuser,   // [1:0] mode, [2] kernel_side
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [71:0]                      m_tdata,   // [55:0] got_addr, [68:56] free_pages
    output logic [1:0]                       m_tuser,   // [1:0] status
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trpfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trpfl_pkg::ADDR_W-1:0]     cfg_data
);

    trpfl_pkg::ctrl_cmd_t  cmd;
    trpfl_pkg::ctrl_stat_t stat;
    logic                  cfg_we;
    logic [trpfl_pkg::ADDR_W-1:0] got;
    logic [trpfl_pkg::STAT_W-1:0] status;
    logic [trpfl_pkg::CNT_W-1:0]  free_pages;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    trpfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser[1:0]),
        .cfg_we   (cfg_we),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    trpfl_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_side        (s_tuser[2]),
        .in_page        (s_tdata),
        .out_got        (got),
        .out_status     (status),
        .out_free_pages (free_pages)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, free_pages, got};
    assign m_tuser = status;

endmodule
